// ----- hw/rtl/lka_pkg.sv -----
package lka_pkg;

    localparam int WORD_W  = 64;
    localparam int INDEX_W = 10;
    localparam int LEVEL_W = 3;

    // Request type codes.
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_MASK  = 2'd1;
    localparam logic [1:0] REQ_KEY   = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Response status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_CONFIG = 2'd1;
    localparam logic [1:0] ST_BAD_LEVEL  = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE_LOG    = 2'd0;
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd1;
    localparam logic [1:0] CFG_OUT_LEN     = 2'd2;

    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_MASK,
        OP_KEY,
        OP_READ,
        OP_ERR
    } op_t;

    typedef struct packed {
        logic [5:0]  base_log;
        logic [3:0]  level_count;
        logic [10:0] out_len;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [1:0]          status;
        logic [WORD_W-1:0]   word;
        logic [LEVEL_W-1:0]  level;
        logic [INDEX_W-1:0]  out_index;
    } entry_t;

endpackage

// ----- hw/rtl/lka_req_if.sv -----
interface lka_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [lka_pkg::WORD_W-1:0]  word;
    logic [lka_pkg::LEVEL_W-1:0] level;
    logic [lka_pkg::INDEX_W-1:0] out_index;

    modport source (output valid, req_type, word, level, out_index, input ready);
    modport sink   (input valid, req_type, word, level, out_index, output ready);
endinterface

// ----- hw/rtl/lka_rsp_if.sv -----
interface lka_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lka_pkg::WORD_W-1:0] read_data;
    logic [1:0]                 status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface

// ----- hw/rtl/lka_cfg_if.sv -----
interface lka_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/lka_front.sv -----
module lka_front #(
    parameter int MAX_OUT_SIZE = 1024,
    parameter int MAX_LEVELS   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    lka_req_if.sink           req,
    lka_cfg_if.sink           cfg,
    input  logic              q_ready,
    input  logic              init_busy,
    output logic              q_push,
    output lka_pkg::entry_t   q_entry,
    output lka_pkg::cfg_t     cfg_out
);

    lka_pkg::cfg_t cfg_reg;
    logic [9:0]    span;
    logic          cfg_ok;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_log    <= 6'd4;
            cfg_reg.level_count <= 4'd1;
            cfg_reg.out_len     <= 11'd2;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lka_pkg::CFG_BASE_LOG:    cfg_reg.base_log    <= cfg.data[5:0];
                lka_pkg::CFG_LEVEL_COUNT: cfg_reg.level_count <= cfg.data[3:0];
                lka_pkg::CFG_OUT_LEN:     cfg_reg.out_len     <= cfg.data;
                default: ;
            endcase
        end
    end

    assign span = 10'(cfg_reg.level_count) * 10'(cfg_reg.base_log);

    always_comb
    begin
        cfg_ok = (cfg_reg.base_log != 6'd0) && (cfg_reg.level_count != 4'd0)
              && (32'(cfg_reg.level_count) <= MAX_LEVELS) && (span < 10'd64)
              && (cfg_reg.out_len != 11'd0)
              && (32'(cfg_reg.out_len) <= MAX_OUT_SIZE);
    end

    assign req.ready = q_ready && !init_busy;
    assign q_push    = req.valid && req.ready;

    always_comb
    begin
        q_entry.word      = req.word;
        q_entry.level     = req.level;
        q_entry.out_index = req.out_index;
        q_entry.status    = lka_pkg::ST_OK;
        q_entry.op        = lka_pkg::OP_ERR;
        if (!cfg_ok)
        begin
            q_entry.status = lka_pkg::ST_BAD_CONFIG;
        end
        else
        begin
            unique case (req.req_type)
                lka_pkg::REQ_BEGIN: q_entry.op = lka_pkg::OP_BEGIN;
                lka_pkg::REQ_MASK:  q_entry.op = lka_pkg::OP_MASK;
                lka_pkg::REQ_KEY:
                begin
                    if (4'(req.level) >= cfg_reg.level_count)
                        q_entry.status = lka_pkg::ST_BAD_LEVEL;
                    else if (11'(req.out_index) >= cfg_reg.out_len)
                        q_entry.status = lka_pkg::ST_BAD_INDEX;
                    else
                        q_entry.op = lka_pkg::OP_KEY;
                end
                default:
                begin
                    if (11'(req.out_index) >= cfg_reg.out_len)
                        q_entry.status = lka_pkg::ST_BAD_INDEX;
                    else
                        q_entry.op = lka_pkg::OP_READ;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/lka_queue.sv -----
module lka_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lka_pkg::entry_t push_entry,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output lka_pkg::entry_t head_entry
);

    lka_pkg::entry_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- hw/rtl/lka_back.sv -----
module lka_back #(
    parameter int MAX_OUT_SIZE = 1024,
    parameter int MAX_LEVELS   = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lka_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  lka_pkg::entry_t head_entry,
    output logic            pop,
    output logic            init_busy,
    lka_rsp_if.source       rsp
);

    localparam int AW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    typedef enum logic [3:0] {
        S_INIT_CLR, S_IDLE, S_CLR, S_BODY, S_MASK_INIT, S_MASK_STEP,
        S_K0, S_K1, S_K2, S_K3, S_R0, S_R1, S_RES
    } state_t;

    state_t          state_reg;
    lka_pkg::entry_t cur_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic [LW-1:0]   lvl_reg;
    logic [63:0]     st_reg;
    logic [63:0]     prod_reg;
    logic [63:0]     digit_reg [MAX_LEVELS];
    logic [63:0]     res_data_reg;
    logic [1:0]      res_status_reg;
    logic            out_valid_reg;
    logic [63:0]     out_data_reg;
    logic [1:0]      out_status_reg;

    // Accumulator memory: bit 64 marks an entry written since the last begin.
    logic [64:0]     mem [MAX_OUT_SIZE];
    logic [64:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [64:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   idx_addr;

    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic [63:0]     mul_p;
    logic [63:0]     dsel;
    logic            out_free;

    logic [9:0]      span;
    logic [6:0]      non_rep;
    logic [6:0]      sh;
    logic [63:0]     rounded;
    logic [63:0]     digit_mask;
    logic [63:0]     d;
    logic [63:0]     st_shift;
    logic [63:0]     carry;
    logic [63:0]     old_val;

    assign init_busy     = (state_reg == S_INIT_CLR);
    assign out_free      = !out_valid_reg || rsp.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.status    = out_status_reg;
    assign pop           = (state_reg == S_IDLE) && head_valid;
    assign idx_addr      = AW'(cur_reg.out_index);
    assign dsel          = digit_reg[LW'(cur_reg.level)];

    // Rounding to the represented top bits of the mask element.
    assign span       = 10'(cfg.level_count) * 10'(cfg.base_log);
    assign non_rep    = 7'd64 - span[6:0];
    assign sh         = non_rep - 7'd1;
    assign rounded    = (((cur_reg.word >> sh) + 64'd1) & ~64'd1) << sh;
    assign digit_mask = (64'd1 << cfg.base_log) - 64'd1;

    // One balanced digit per step.
    assign d        = st_reg & digit_mask;
    assign st_shift = st_reg >> cfg.base_log;
    assign carry    = (((d - 64'd1) | st_shift) & d) >> (cfg.base_log - 6'd1);

    assign old_val = rdata_reg[64] ? rdata_reg[63:0] : 64'd0;

    always_comb
    begin
        case (state_reg)
            S_K1:    begin mul_a = cur_reg.word[31:0];  mul_b = dsel[63:32]; end
            S_K2:    begin mul_a = cur_reg.word[63:32]; mul_b = dsel[31:0];  end
            default: begin mul_a = cur_reg.word[31:0];  mul_b = dsel[31:0];  end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        mem_re    = (state_reg == S_K0) || (state_reg == S_R0);
        case (state_reg)
            S_INIT_CLR, S_CLR: mem_we = 1'b1;
            S_BODY:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cfg.out_len - 11'd1);
                mem_wdata = {1'b1, cur_reg.word};
            end
            S_K3:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_addr;
                mem_wdata = {1'b1, old_val - prod_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[idx_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT_CLR;
            cur_reg        <= '0;
            clr_addr_reg   <= '0;
            lvl_reg        <= '0;
            st_reg         <= '0;
            prod_reg       <= '0;
            res_data_reg   <= '0;
            res_status_reg <= lka_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= lka_pkg::ST_OK;
            for (int i = 0; i < MAX_LEVELS; i++)
                digit_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == S_RES && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT_CLR, S_CLR:
                begin
                    if (clr_addr_reg == AW'(MAX_OUT_SIZE - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= (state_reg == S_CLR) ? S_BODY : S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cur_reg        <= head_entry;
                        res_data_reg   <= '0;
                        res_status_reg <= head_entry.status;
                        unique case (head_entry.op)
                            lka_pkg::OP_BEGIN: state_reg <= S_CLR;
                            lka_pkg::OP_MASK:  state_reg <= S_MASK_INIT;
                            lka_pkg::OP_KEY:   state_reg <= S_K0;
                            lka_pkg::OP_READ:  state_reg <= S_R0;
                            default:           state_reg <= S_RES;
                        endcase
                    end
                end
                S_BODY: state_reg <= S_RES;
                S_MASK_INIT:
                begin
                    st_reg    <= rounded >> non_rep;
                    lvl_reg   <= '0;
                    state_reg <= S_MASK_STEP;
                end
                S_MASK_STEP:
                begin
                    if (7'(lvl_reg) < 7'(cfg.level_count))
                    begin
                        digit_reg[lvl_reg] <= d - (carry << cfg.base_log);
                        st_reg             <= st_shift + carry;
                    end
                    else
                    begin
                        digit_reg[lvl_reg] <= '0;
                    end
                    lvl_reg <= lvl_reg + LW'(1);
                    if (lvl_reg == LW'(MAX_LEVELS - 1))
                        state_reg <= S_RES;
                end
                S_K0:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_K1;
                end
                S_K1:
                begin
                    prod_reg  <= prod_reg + {mul_p[31:0], 32'd0};
                    state_reg <= S_K2;
                end
                S_K2:
                begin
                    prod_reg  <= prod_reg + {mul_p[31:0], 32'd0};
                    state_reg <= S_K3;
                end
                S_K3: state_reg <= S_RES;
                S_R0: state_reg <= S_R1;
                S_R1:
                begin
                    res_data_reg <= old_val;
                    state_reg    <= S_RES;
                end
                S_RES:
                begin
                    if (out_free)
                    begin
                        out_data_reg   <= res_data_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/lwe_keyswitch_accumulator.sv -----
// LWE key switch accumulator, arithmetic modulo 2^64.
// Requests arrive on the req channel: a begin request clears the accumulator
// and stores the body, a mask request decomposes a mask element into signed
// digits, a key request subtracts key word times digit from one entry, and a
// read request returns one entry. Every request gives exactly one response on
// the rsp channel, in request order, carrying read data and a status code.
// Configuration registers are written through the cfg channel; the user
// must write them only while idle, since the block does not enforce it.
// A front stage checks each request against the configuration and queues it
// in a two-entry queue; a back sequencer executes it against a single-port
// accumulator memory, so the front keeps taking requests while the back works.
// In the back sequencer, a key word takes three 32x32 partial products on one
// shared multiplier, then the read-modify-write; a read fetches one entry; a
// mask gives one digit per cycle; a begin clears one memory entry per cycle,
// then writes the body; a rejected request goes straight to its response.
// After reset the req channel is not ready until the back has cleared memory.
// When the receiver stalls, the result waits in the output register, the back
// stalls behind it, and the queue fills before req ready falls.
module lwe_keyswitch_accumulator #(
    parameter int MAX_OUT_SIZE = 1024,
    parameter int MAX_LEVELS   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    lka_req_if.sink   req,
    lka_rsp_if.source rsp,
    lka_cfg_if.sink   cfg
);

    logic            q_push;
    logic            q_ready;
    logic            q_pop;
    logic            q_valid;
    logic            init_busy;
    lka_pkg::entry_t push_entry;
    lka_pkg::entry_t head_entry;
    lka_pkg::cfg_t   cfg_val;

    // Request checks and configuration registers.
    lka_front #(
        .MAX_OUT_SIZE (MAX_OUT_SIZE),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .q_ready   (q_ready),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .cfg_out   (cfg_val)
    );

    // Decouples request intake from execution.
    lka_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    // Execution sequencer, accumulator memory and output register.
    lka_back #(
        .MAX_OUT_SIZE (MAX_OUT_SIZE),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_val),
        .head_valid (q_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .init_busy  (init_busy),
        .rsp        (rsp)
    );

endmodule

// ----- test/lwe_keyswitch_accumulator_test.sv -----
module lwe_keyswitch_accumulator_test;

    // Expected response for one request, in request order.
    typedef struct {
        logic [lka_pkg::WORD_W-1:0] read_data;
        logic [1:0]                 status;
    } response_t;

    logic clk;
    logic rst_n;

    lka_req_if req_ch();
    lka_rsp_if rsp_ch();
    lka_cfg_if cfg_ch();

    lwe_keyswitch_accumulator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Shadow copy of the block: configuration, accumulator and digits.
    logic [5:0]                 sh_base_log;
    logic [3:0]                 sh_level_count;
    logic [10:0]                sh_out_len;
    logic [lka_pkg::WORD_W-1:0] sh_acc [1024];
    logic                       sh_written [1024];
    logic [lka_pkg::WORD_W-1:0] sh_digit [8];

    response_t pending_rsp[$];
    int        mismatches = 0;
    int        idle_pct   = 0;
    int        stall_pct  = 0;
    int        sent_count = 0;

    // The clock runs with a 4-unit period for the whole run.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run is stopped here if the block hangs.  The slowest correct run,
    // with every begin clearing the memory and heavy stalls, stays well below.
    initial
    begin
        #40000000;
        $display("lwe_keyswitch_accumulator verification failed");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic bit config_good();
        int product;
        product = int'(sh_level_count) * int'(sh_base_log);
        if (sh_base_log == 0 || sh_level_count == 0 || sh_level_count > 8)
            return 0;
        if (product >= 64)
            return 0;
        if (sh_out_len == 0 || sh_out_len > 1024)
            return 0;
        return 1;
    endfunction

    // Round the mask element to the represented top bits and split it into
    // balanced signed digits, carrying from each level into the next one.
    function automatic void split_mask(input logic [63:0] mask_elem);
        int          non_rep;
        int          sh;
        int          bl;
        logic [63:0] digit_mask;
        logic [63:0] rounded;
        logic [63:0] rest;
        logic [63:0] d;
        logic [63:0] c;
        bl         = int'(sh_base_log);
        non_rep    = 64 - int'(sh_level_count) * bl;
        sh         = non_rep - 1;
        digit_mask = (64'd1 << bl) - 64'd1;
        rounded    = (((mask_elem >> sh) + 64'd1) & ~64'd1) << sh;
        rest       = rounded >> non_rep;
        for (int j = 0; j < 8; j++)
        begin
            if (j < int'(sh_level_count))
            begin
                d    = rest & digit_mask;
                rest = rest >> bl;
                c    = ((d - 64'd1) | rest) & d;
                c    = c >> (bl - 1);
                rest = rest + c;
                d    = d - (c << bl);
                sh_digit[j] = d;
            end
            else
            begin
                sh_digit[j] = 64'd0;
            end
        end
    endfunction

    // Work out the response for one accepted request and update the shadow.
    function automatic response_t accumulate(input logic [1:0] kind, input logic [63:0] word,
                                             input logic [2:0] lvl, input logic [9:0] idx);
        response_t r;
        logic [63:0] old;
        r.read_data = '0;
        r.status    = lka_pkg::ST_OK;
        if (!config_good())
            r.status = lka_pkg::ST_BAD_CONFIG;
        else if (kind == lka_pkg::REQ_BEGIN)
        begin
            foreach (sh_written[i])
                sh_written[i] = 1'b0;
            sh_acc[sh_out_len - 1]     = word;
            sh_written[sh_out_len - 1] = 1'b1;
        end
        else if (kind == lka_pkg::REQ_MASK)
            split_mask(word);
        else if (kind == lka_pkg::REQ_KEY)
        begin
            if (lvl >= sh_level_count)
                r.status = lka_pkg::ST_BAD_LEVEL;
            else if (idx >= sh_out_len)
                r.status = lka_pkg::ST_BAD_INDEX;
            else
            begin
                old = sh_written[idx] ? sh_acc[idx] : 64'd0;
                sh_acc[idx]     = old - word * sh_digit[lvl];
                sh_written[idx] = 1'b1;
            end
        end
        else
        begin
            if (idx >= sh_out_len)
                r.status = lka_pkg::ST_BAD_INDEX;
            else
                r.read_data = sh_written[idx] ? sh_acc[idx] : 64'd0;
        end
        return r;
    endfunction

    // One process watches all three channels at the rising edge.  Responses
    // are checked before the request of the same edge is predicted; a request
    // can never be answered in the cycle it is accepted.
    always @(posedge clk)
    begin
        response_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
                report("response with no request waiting", {62'd0, rsp_ch.status}, 64'd0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report("status", {62'd0, rsp_ch.status}, {62'd0, want.status});
                if (rsp_ch.read_data !== want.read_data)
                    report("read_data", rsp_ch.read_data, want.read_data);
            end
        end
        if (req_ch.valid && req_ch.ready)
            pending_rsp.push_back(accumulate(req_ch.req_type, req_ch.word,
                                             req_ch.level, req_ch.out_index));
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == lka_pkg::CFG_BASE_LOG)
                sh_base_log = cfg_ch.data[5:0];
            else if (cfg_ch.index == lka_pkg::CFG_LEVEL_COUNT)
                sh_level_count = cfg_ch.data[3:0];
            else if (cfg_ch.index == lka_pkg::CFG_OUT_LEN)
                sh_out_len = cfg_ch.data;
        end
    end

    // The receiver stalls at random; the rate is set per phase.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Send one request.  Valid is left high on return so that back-to-back
    // requests keep it asserted; an idle gap lowers it first.
    task automatic send(input logic [1:0] kind, input logic [63:0] word,
                        input logic [2:0] lvl, input logic [9:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.req_type  = kind;
        req_ch.word      = word;
        req_ch.level     = lvl;
        req_ch.out_index = idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_count++;
        @(negedge clk);
    endtask

    // Hold the request channel quiet until every response has come back.
    task automatic drain();
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        drain();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_config(input int bl, input int lc, input int osz);
        write_reg(lka_pkg::CFG_BASE_LOG, 11'(bl));
        write_reg(lka_pkg::CFG_LEVEL_COUNT, 11'(lc));
        write_reg(lka_pkg::CFG_OUT_LEN, 11'(osz));
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Under the reset configuration: base 16, one level, two entries.
    task automatic test_reset_defaults();
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd0);
        send(lka_pkg::REQ_KEY, '1, 3'd0, 10'd0);     // digits are still zero after reset
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd0);
        send(lka_pkg::REQ_BEGIN, 64'h0123_4567_89ab_cdef, 3'd0, 10'd0);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd1);
        send(lka_pkg::REQ_MASK, 64'h0800_0000_0000_0000, 3'd0, 10'd0);  // rounds up with carry
        send(lka_pkg::REQ_KEY, '1, 3'd0, 10'd1);
        send(lka_pkg::REQ_KEY, 64'd5, 3'd7, 10'd0);  // level beyond the count
        send(lka_pkg::REQ_KEY, 64'd5, 3'd0, 10'd1023); // index beyond the size
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd2);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd0);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd1);
    endtask

    // Each broken configuration must reject the request sent under it; the kinds rotate.
    task automatic test_bad_config();
        int bad [5][3] = '{'{0, 1, 4}, '{4, 0, 4}, '{4, 9, 4}, '{8, 8, 4}, '{4, 2, 0}};
        for (int k = 0; k < 5; k++)
        begin
            set_config(bad[k][0], bad[k][1], bad[k][2]);
            send(2'(k % 4), rand_word(), 3'd0, 10'd0);
        end
        set_config(4, 2, 1025);
        send(lka_pkg::REQ_KEY, '1, 3'd0, 10'd0);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd0);
    endtask

    // Extremes: widest digit, most levels, largest accumulator.
    task automatic test_extremes();
        set_config(63, 1, 1024);
        send(lka_pkg::REQ_BEGIN, '1, 3'd0, 10'd0);
        send(lka_pkg::REQ_MASK, '1, 3'd0, 10'd0);
        send(lka_pkg::REQ_KEY, '1, 3'd0, 10'd1023);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd1023);
        set_config(1, 8, 1024);
        send(lka_pkg::REQ_MASK, 64'h5a5a_5a5a_5a5a_5a5a, 3'd0, 10'd0);
        send(lka_pkg::REQ_KEY, {$urandom, $urandom}, 3'd7, 10'd512);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd512);
        set_config(7, 8, 2);
        send(lka_pkg::REQ_MASK, 64'hffff_ffff_ffff_fff0, 3'd0, 10'd0);
        send(lka_pkg::REQ_KEY, 64'd3, 3'd7, 10'd0);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd0);
    endtask

    // One key switch: begin, several masks each followed by its key words,
    // then reads of the outputs, with a little noise mixed in.
    task automatic switch_burst();
        int osz;
        int lc;
        osz = int'(sh_out_len);
        lc  = int'(sh_level_count);
        send(lka_pkg::REQ_BEGIN, rand_word(), 3'($urandom), 10'($urandom));
        repeat ($urandom_range(1, 4))
        begin
            send(lka_pkg::REQ_MASK, rand_word(), 3'($urandom), 10'($urandom));
            for (int l = 0; l < lc; l++)
                repeat ($urandom_range(1, 2))
                    send(lka_pkg::REQ_KEY, rand_word(), 3'(l),
                         10'($urandom_range(osz - 1)));
            if ($urandom_range(3) == 0)
                send(2'($urandom), {$urandom, $urandom}, 3'($urandom), 10'($urandom));
        end
        repeat ($urandom_range(1, 6))
            send(lka_pkg::REQ_READ, '0, 3'($urandom), 10'($urandom_range(osz - 1)));
    endtask

    task automatic pick_config();
        int lc;
        int bl;
        int osz;
        lc  = $urandom_range(1, 8);
        bl  = $urandom_range(1, 63 / lc);
        if ((63 / lc) >= 1 && $urandom_range(5) == 0)
            bl = 63 / lc;
        osz = ($urandom_range(9) == 0) ? 1024 : $urandom_range(2, 16);
        set_config(bl, lc, osz);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = sent_count;
        while (sent_count - start < count)
        begin
            if ($urandom_range(3) == 0)
                pick_config();
            switch_burst();
        end
    endtask

    // Pause the sender until everything is answered, then resume.
    task automatic test_full_drain();
        idle_pct  = 0;
        stall_pct = 65;
        set_config(16, 3, 8);
        send(lka_pkg::REQ_BEGIN, rand_word(), 3'd0, 10'd0);
        send(lka_pkg::REQ_MASK, rand_word(), 3'd0, 10'd0);
        send(lka_pkg::REQ_KEY, rand_word(), 3'd2, 10'd7);
        drain();
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd7);
        send(lka_pkg::REQ_READ, '0, 3'd0, 10'd6);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = lka_pkg::REQ_BEGIN;
        req_ch.word      = '0;
        req_ch.level     = '0;
        req_ch.out_index = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = lka_pkg::CFG_BASE_LOG;
        cfg_ch.data      = '0;
        sh_base_log      = 6'd4;
        sh_level_count   = 4'd1;
        sh_out_len       = 11'd2;
        foreach (sh_written[i])
        begin
            sh_written[i] = 1'b0;
            sh_acc[i]     = '0;
        end
        foreach (sh_digit[i])
            sh_digit[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_bad_config();
        test_extremes();
        test_full_drain();
        test_random_phase(0, 0, 360);
        test_random_phase(65, 0, 360);
        test_random_phase(0, 65, 360);
        test_random_phase(30, 30, 360);

        drain();
        repeat (40) @(negedge clk);
        if (pending_rsp.size() != 0)
            report("responses never returned", 64'(pending_rsp.size()), 64'd0);
        if (mismatches == 0)
            $display("lwe_keyswitch_accumulator verification clean");
        else
            $display("lwe_keyswitch_accumulator verification failed");
        $finish;
    end
endmodule
